[hdl/nfa_pkg.sv]
// ----------------------------------------------------------------------------
// nfa_pkg: shared types and constants for the NFA word acceptor
// Sizes, operation codes, sequencer states, edge RAM request and helpers.
// ----------------------------------------------------------------------------
package nfa_pkg;

    localparam int NUM_STATES  = 16;
    localparam int SYMBOL_BITS = 8;
    localparam int STATE_W     = 4;                     // from_state / to_state field
    localparam int SYM_W       = 8;                     // symbol field
    localparam int OP_W        = 3;
    localparam int MEM_ADDR_W  = STATE_W + SYMBOL_BITS; // {source, symbol}
    localparam int MEM_DEPTH   = 1 << MEM_ADDR_W;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;

    localparam logic [SYM_W-1:0] DOT_SYMBOL = 8'h2E;

    localparam logic [OP_W-1:0] OP_CLEAR = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 3'd1;
    localparam logic [OP_W-1:0] OP_MARK  = 3'd2;
    localparam logic [OP_W-1:0] OP_FEED  = 3'd3;
    localparam logic [OP_W-1:0] OP_END   = 3'd4;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_FEED,
        ST_FEED_LAST,
        ST_END
    } state_t;

    typedef logic [NUM_STATES-1:0] set_t;

    typedef struct packed {
        logic                  we;
        logic [MEM_ADDR_W-1:0] addr;
        set_t                  wdata;
    } ram_req_t;

    function automatic logic state_ok(input logic [STATE_W-1:0] s);
        return (32'(s) < 32'(NUM_STATES));
    endfunction

    function automatic logic sym_in_range(input logic [SYM_W-1:0] c);
        return ((c >> SYMBOL_BITS) == '0);
    endfunction

    // space, tab, LF, VT, FF, CR never match as labels
    function automatic logic is_blank(input logic [SYM_W-1:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

endpackage

[hdl/nfa_word_acceptor.sv]
// ----------------------------------------------------------------------------
// nfa_word_acceptor: set-of-states NFA word matcher
// Loads an automaton edge by edge, feeds characters through the active state
// set, and reports acceptance at each end of word.
// ----------------------------------------------------------------------------
//
//  channel | dir | beat contents                                  | when
//  --------+-----+------------------------------------------------+-------------
//  s_*     | in  | operation, from_state, to_state, symbol, wild  | sequencer idle
//  m_*     | out | accepted                                       | end of word
//
//  Mark and wildcard add edge beats update registers only; an add edge with
//  a symbol label does a read-modify-write of its edge RAM row; a feed
//  character reads the single-port edge RAM one row per state; an end word
//  waits out any output stall. After reset and after a clear the RAM is
//  swept to zero, one row a cycle; s_tready stays low during the sweep.
//  The result register lets m_tvalid wait on m_tready while further load and
//  feed beats are taken; an end word waits only if that register is full.
//
// ----------------------------------------------------------------------------
module nfa_word_acceptor (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [23:0] s_tdata,   // [2:0] operation, [6:3] from_state,
                                   // [10:7] to_state, [18:11] symbol,
                                   // [19] wildcard_req, [23:20] zero

    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata     // [0] accepted, [7:1] zero
);

    // ---- state ----------------------------------------------------------
    nfa_pkg::state_t state_reg, state_next;

    logic [nfa_pkg::MEM_ADDR_W-1:0] clr_cnt_reg,  clr_cnt_next;
    logic [nfa_pkg::STATE_W-1:0]    feed_cnt_reg, feed_cnt_next;

    // latched item
    logic [nfa_pkg::STATE_W-1:0] from_reg, from_next;
    logic [nfa_pkg::STATE_W-1:0] to_reg,   to_next;
    logic [nfa_pkg::SYM_W-1:0]   sym_reg,  sym_next;

    // automaton and run state
    nfa_pkg::set_t wild_rows_reg [nfa_pkg::NUM_STATES];
    nfa_pkg::set_t wild_rows_next[nfa_pkg::NUM_STATES];
    nfa_pkg::set_t acc_mask_reg,  acc_mask_next;
    nfa_pkg::set_t active_reg,    active_next;
    nfa_pkg::set_t gather_reg,    gather_next;   // next set being built
    logic          pend_reg,      pend_next;     // RAM row due this cycle counts

    logic out_valid_reg, out_valid_next;
    logic out_acc_reg,   out_acc_next;

    // ---- input decode -----------------------------------------------------
    logic                        accept;
    logic [nfa_pkg::OP_W-1:0]    in_op;
    logic [nfa_pkg::STATE_W-1:0] in_from;
    logic [nfa_pkg::STATE_W-1:0] in_to;
    logic [nfa_pkg::SYM_W-1:0]   in_sym;
    logic                        in_wild;
    logic                        in_states_ok;
    logic                        in_wild_eff;
    logic                        in_sym_store;
    logic                        out_free;
    logic                        feed_last;

    nfa_pkg::ram_req_t ram_req;
    nfa_pkg::set_t     ram_rd;

    localparam nfa_pkg::set_t SET_START = nfa_pkg::set_t'(1);

    assign in_op   = s_tdata[2:0];
    assign in_from = s_tdata[6:3];
    assign in_to   = s_tdata[10:7];
    assign in_sym  = s_tdata[18:11];
    assign in_wild = s_tdata[19];

    assign s_tready = (state_reg == nfa_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign in_states_ok = nfa_pkg::state_ok(in_from) && nfa_pkg::state_ok(in_to);
    // a dot label is the wildcard
    assign in_wild_eff  = in_wild || (in_sym == nfa_pkg::DOT_SYMBOL);
    assign in_sym_store = nfa_pkg::sym_in_range(in_sym) && !nfa_pkg::is_blank(in_sym);

    assign out_free  = !out_valid_reg || m_tready;
    assign feed_last = (feed_cnt_reg == nfa_pkg::STATE_W'(nfa_pkg::NUM_STATES - 1));

    // ---- edge RAM ---------------------------------------------------------
    nfa_edge_ram u_edge_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (ram_rd)
    );

    // ---- next state -------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nfa_pkg::ST_CLEAR:
            begin
                if (&clr_cnt_reg)
                begin
                    state_next = nfa_pkg::ST_IDLE;
                end
            end
            nfa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_op)
                        nfa_pkg::OP_CLEAR: state_next = nfa_pkg::ST_CLEAR;
                        nfa_pkg::OP_ADD:
                        begin
                            if (in_states_ok && !in_wild_eff && in_sym_store)
                            begin
                                state_next = nfa_pkg::ST_ADD_RD;
                            end
                        end
                        nfa_pkg::OP_FEED:  state_next = nfa_pkg::ST_FEED;
                        nfa_pkg::OP_END:   state_next = nfa_pkg::ST_END;
                        default:           state_next = nfa_pkg::ST_IDLE;
                    endcase
                end
            end
            nfa_pkg::ST_ADD_RD:    state_next = nfa_pkg::ST_ADD_WR;
            nfa_pkg::ST_ADD_WR:    state_next = nfa_pkg::ST_IDLE;
            nfa_pkg::ST_FEED:
            begin
                if (feed_last)
                begin
                    state_next = nfa_pkg::ST_FEED_LAST;
                end
            end
            nfa_pkg::ST_FEED_LAST: state_next = nfa_pkg::ST_IDLE;
            nfa_pkg::ST_END:
            begin
                if (out_free)
                begin
                    state_next = nfa_pkg::ST_IDLE;
                end
            end
            default:               state_next = nfa_pkg::ST_IDLE;
        endcase
    end

    // ---- datapath and outputs ---------------------------------------------
    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        feed_cnt_next  = feed_cnt_reg;
        from_next      = from_reg;
        to_next        = to_reg;
        sym_next       = sym_reg;
        wild_rows_next = wild_rows_reg;
        acc_mask_next  = acc_mask_reg;
        active_next    = active_reg;
        gather_next    = gather_reg;
        pend_next      = pend_reg;
        out_acc_next   = out_acc_reg;
        out_valid_next = out_valid_reg && !m_tready;

        ram_req.we    = 1'b0;
        ram_req.addr  = {from_reg, sym_reg[nfa_pkg::SYMBOL_BITS-1:0]};
        ram_req.wdata = ram_rd | (SET_START << to_reg);

        unique case (state_reg)
            nfa_pkg::ST_CLEAR:
            begin
                ram_req.we    = 1'b1;
                ram_req.addr  = clr_cnt_reg;
                ram_req.wdata = '0;
                clr_cnt_next  = clr_cnt_reg + 1'b1;
            end
            nfa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    from_next     = in_from;
                    to_next       = in_to;
                    sym_next      = in_sym;
                    gather_next   = '0;
                    pend_next     = 1'b0;
                    feed_cnt_next = '0;
                    unique case (in_op)
                        nfa_pkg::OP_CLEAR:
                        begin
                            for (int i = 0; i < nfa_pkg::NUM_STATES; i++)
                            begin
                                wild_rows_next[i] = '0;
                            end
                            acc_mask_next = '0;
                            active_next   = SET_START;
                            clr_cnt_next  = '0;
                        end
                        nfa_pkg::OP_ADD:
                        begin
                            if (in_states_ok && in_wild_eff)
                            begin
                                wild_rows_next[in_from][in_to] = 1'b1;
                            end
                        end
                        nfa_pkg::OP_MARK:
                        begin
                            if (nfa_pkg::state_ok(in_from))
                            begin
                                acc_mask_next[in_from] = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            nfa_pkg::ST_ADD_RD:
            begin
            end
            nfa_pkg::ST_ADD_WR:
            begin
                ram_req.we = 1'b1;
            end
            nfa_pkg::ST_FEED:
            begin
                // read row of state feed_cnt; the row read last cycle lands now
                ram_req.addr  = {feed_cnt_reg, sym_reg[nfa_pkg::SYMBOL_BITS-1:0]};
                pend_next     = active_reg[feed_cnt_reg] && nfa_pkg::sym_in_range(sym_reg);
                gather_next   = gather_reg
                              | (active_reg[feed_cnt_reg] ? wild_rows_reg[feed_cnt_reg] : '0)
                              | (pend_reg ? ram_rd : '0);
                feed_cnt_next = feed_cnt_reg + 1'b1;
            end
            nfa_pkg::ST_FEED_LAST:
            begin
                active_next = gather_reg | (pend_reg ? ram_rd : '0);
            end
            nfa_pkg::ST_END:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_acc_next   = |(active_reg & acc_mask_reg);
                    active_next    = SET_START;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ---- registers --------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nfa_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            feed_cnt_reg  <= '0;
            for (int i = 0; i < nfa_pkg::NUM_STATES; i++)
            begin
                wild_rows_reg[i] <= '0;
            end
            acc_mask_reg  <= '0;
            active_reg    <= SET_START;
            gather_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            feed_cnt_reg  <= feed_cnt_next;
            wild_rows_reg <= wild_rows_next;
            acc_mask_reg  <= acc_mask_next;
            active_reg    <= active_next;
            gather_reg    <= gather_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        from_reg    <= from_next;
        to_reg      <= to_next;
        sym_reg     <= sym_next;
        out_acc_reg <= out_acc_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_acc_reg};

endmodule

[hdl/nfa_edge_ram.sv]
// ----------------------------------------------------------------------------
// nfa_edge_ram: symbol edge table
// Single-port RAM, one row of target states per {source, symbol}.
// Registered read; read during write returns the old row.
// ----------------------------------------------------------------------------
module nfa_edge_ram (
    input  logic              clk,
    input  nfa_pkg::ram_req_t req,
    output nfa_pkg::set_t     rd_data
);

    nfa_pkg::set_t mem [nfa_pkg::MEM_DEPTH];
    nfa_pkg::set_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        rd_data_reg <= mem[req.addr];
    end

    assign rd_data = rd_data_reg;

endmodule
